// ===== src/bbx_pkg.sv =====
package bbx_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned ProdW  = 2 * CoordW;
  // Product after the Q16.16 realignment, plus one bit for the offset add.
  localparam int unsigned FracW  = 16;
  localparam int unsigned WidenW = ProdW - FracW + 1;
  // Bound plus or minus the widening amount.
  localparam int unsigned SumW   = WidenW + 1;
  localparam int unsigned NumAxes = 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [WidenW-1:0] widen_t;
  typedef logic signed [SumW-1:0]   sum_t;

  localparam coord_t BoundMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam coord_t BoundMin = {1'b1, {(CoordW-1){1'b0}}};

  typedef enum logic [1:0] {
    CFG_BIAS_ENABLE = 2'd0,
    CFG_BIAS_SCALE  = 2'd1,
    CFG_BIAS_OFFSET = 2'd2
  } cfg_reg_e;

  typedef logic [1:0] cfg_idx_t;

  typedef struct packed {
    logic   enable;
    coord_t scale;
    coord_t offset;
  } bias_cfg_t;

  // Point transfer and per-stage load enables shared by all lanes.
  typedef struct packed {
    logic fire;
    logic last;
    logic ld_mul;
    logic ld_widen;
  } lane_ctrl_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic coord_t sat_coord(sum_t v);
    coord_t r;
    if (v[SumW-1:CoordW-1] == {(SumW-CoordW+1){v[SumW-1]}}) begin
      r = v[CoordW-1:0];
    end else if (v[SumW-1]) begin
      r = BoundMin;
    end else begin
      r = BoundMax;
    end
    return r;
  endfunction

endpackage

// ===== src/bbx_if.sv =====
interface bbx_point_if;
  logic            valid;
  logic            ready;
  bbx_pkg::coord_t point_x;
  bbx_pkg::coord_t point_y;
  bbx_pkg::coord_t point_z;
  logic            last_point;

  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface bbx_box_if;
  logic            valid;
  logic            ready;
  bbx_pkg::coord_t min_x;
  bbx_pkg::coord_t min_y;
  bbx_pkg::coord_t min_z;
  bbx_pkg::coord_t max_x;
  bbx_pkg::coord_t max_y;
  bbx_pkg::coord_t max_z;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface bbx_cfg_if;
  logic              valid;
  logic              ready;
  bbx_pkg::cfg_idx_t index;
  bbx_pkg::coord_t   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/bbx_lane.sv =====
module bbx_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bbx_pkg::lane_ctrl_t ctrl_i,
  input  bbx_pkg::coord_t     coord_i,
  input  bbx_pkg::bias_cfg_t  cfg_i,
  output bbx_pkg::coord_t     lo_o,
  output bbx_pkg::coord_t     hi_o
);
  import bbx_pkg::*;

  coord_t run_min_q, run_min_d;
  coord_t run_max_q, run_max_d;
  coord_t fold_min, fold_max;

  // Stage one: final bounds of a set.
  coord_t s1_lo_q, s1_hi_q;
  // Stage two: scaled products.
  prod_t  s2_lo_prod_q, s2_hi_prod_q;
  coord_t s2_lo_q, s2_hi_q;
  // Stage three: widening amounts.
  widen_t s3_lo_wid_q, s3_hi_wid_q;
  coord_t s3_lo_q, s3_hi_q;

  prod_t  lo_prod, hi_prod;
  widen_t lo_wid, hi_wid;
  sum_t   lo_sum, hi_sum;

  assign fold_min = (coord_i < run_min_q) ? coord_i : run_min_q;
  assign fold_max = (coord_i > run_max_q) ? coord_i : run_max_q;

  always_comb begin
    run_min_d = run_min_q;
    run_max_d = run_max_q;
    if (ctrl_i.fire) begin
      if (ctrl_i.last) begin
        run_min_d = BoundMax;
        run_max_d = BoundMin;
      end else begin
        run_min_d = fold_min;
        run_max_d = fold_max;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_min_q <= BoundMax;
      run_max_q <= BoundMin;
    end else begin
      run_min_q <= run_min_d;
      run_max_q <= run_max_d;
    end
  end

  assign lo_prod = ProdW'(s1_lo_q) * ProdW'(cfg_i.scale);
  assign hi_prod = ProdW'(s1_hi_q) * ProdW'(cfg_i.scale);

  // Dropping the low fraction bits of a signed product rounds toward minus infinity.
  assign lo_wid = WidenW'($signed(s2_lo_prod_q[ProdW-1:FracW])) + WidenW'(cfg_i.offset);
  assign hi_wid = WidenW'($signed(s2_hi_prod_q[ProdW-1:FracW])) + WidenW'(cfg_i.offset);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire && ctrl_i.last) begin
      s1_lo_q <= fold_min;
      s1_hi_q <= fold_max;
    end
    if (ctrl_i.ld_mul) begin
      s2_lo_prod_q <= lo_prod;
      s2_hi_prod_q <= hi_prod;
      s2_lo_q      <= s1_lo_q;
      s2_hi_q      <= s1_hi_q;
    end
    if (ctrl_i.ld_widen) begin
      s3_lo_wid_q <= lo_wid;
      s3_hi_wid_q <= hi_wid;
      s3_lo_q     <= s2_lo_q;
      s3_hi_q     <= s2_hi_q;
    end
  end

  assign lo_sum = SumW'(s3_lo_q) - SumW'(s3_lo_wid_q);
  assign hi_sum = SumW'(s3_hi_q) + SumW'(s3_hi_wid_q);

  assign lo_o = cfg_i.enable ? sat_coord(lo_sum) : s3_lo_q;
  assign hi_o = cfg_i.enable ? sat_coord(hi_sum) : s3_hi_q;

`ifndef SYNTH
  a_restart_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.fire && ctrl_i.last |=> run_min_q == BoundMax && run_max_q == BoundMin)
    else $error("running bounds not restarted after last point");

  a_min_not_above_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_min_q <= run_max_q) || (run_min_q == BoundMax && run_max_q == BoundMin))
    else $error("running minimum above running maximum");

  a_min_tracks_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.fire && !ctrl_i.last && coord_i < run_min_q |=> run_min_q == $past(coord_i))
    else $error("running minimum missed a smaller point");
`endif

endmodule

// ===== src/bbx_merge.sv =====
module bbx_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  bbx_pkg::coord_t [2:0] lo_i,
  input  bbx_pkg::coord_t [2:0] hi_i,
  bbx_box_if.source             box_o
);
  import bbx_pkg::*;

  logic   valid_q, valid_d;
  coord_t [2:0] lo_q, hi_q;

  assign ready_o = !valid_q || box_o.ready;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      lo_q <= lo_i;
      hi_q <= hi_i;
    end
  end

  assign box_o.valid = valid_q;
  assign box_o.min_x = lo_q[0];
  assign box_o.min_y = lo_q[1];
  assign box_o.min_z = lo_q[2];
  assign box_o.max_x = hi_q[0];
  assign box_o.max_y = hi_q[1];
  assign box_o.max_z = hi_q[2];

endmodule

// ===== src/bounding_box_extractor_core.sv =====
// After the last point of a set is taken, its bounds pass stage one, the multiply stage,
// the widen stage and the saturating output register, where the box is offered.
// Throughput: one point per cycle unless the result path is full, sets back to back,
// one box per set. A stalled output backs up that path; points are refused only once all
// four of its stages are full. Reset clears the bias registers to zero, the running bounds to
// their extremes and empties the result path.
module bounding_box_extractor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  bbx_cfg_if.sink     cfg_i,
  bbx_point_if.sink   pnt_i,
  bbx_box_if.source   box_o
);
  import bbx_pkg::*;

  // Configuration registers. Writes are expected only while the block is idle,
  // so every stage reads them directly.
  bias_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_BIAS_ENABLE: cfg_d.enable = cfg_i.data[0];
        CFG_BIAS_SCALE:  cfg_d.scale  = cfg_i.data;
        CFG_BIAS_OFFSET: cfg_d.offset = cfg_i.data;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Occupancy of the three result stages inside the lanes. Each stage takes
  // a new set when it is empty or when the stage after it moves on, so
  // bubbles are squeezed out while the output is stalled.
  logic v1_q, v1_d, v2_q, v2_d, v3_q, v3_d;
  logic rdy1, rdy2, rdy3, rdy_out;
  logic fire;

  assign rdy3 = !v3_q || rdy_out;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  // Ordinary points only update the running bounds; a last point also
  // hands the finished bounds to stage one.
  assign pnt_i.ready = rdy1;
  assign fire        = pnt_i.valid && rdy1;

  assign v1_d = rdy1 ? (fire && pnt_i.last_point) : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  lane_ctrl_t ctrl;

  assign ctrl.fire     = fire;
  assign ctrl.last     = pnt_i.last_point;
  assign ctrl.ld_mul   = rdy2;
  assign ctrl.ld_widen = rdy3;

  coord_t [2:0] coord, lo, hi;

  assign coord[0] = pnt_i.point_x;
  assign coord[1] = pnt_i.point_y;
  assign coord[2] = pnt_i.point_z;

  // One lane per axis; each keeps its running bounds and widens its own pair.
  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    bbx_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .coord_i (coord[g]),
      .cfg_i   (cfg_q),
      .lo_o    (lo[g]),
      .hi_o    (hi[g])
    );
  end

  // The merge stage gathers the six bounds into the output register.
  bbx_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .ready_o (rdy_out),
    .lo_i    (lo),
    .hi_i    (hi),
    .box_o   (box_o)
  );

`ifndef SYNTH
  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q && !v2_q && !v3_q |-> pnt_i.ready)
    else $error("point refused with an empty result path");

  a_stage3_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !rdy_out |=> v3_q)
    else $error("stalled box dropped from the last stage");

  a_last_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pnt_i.valid && pnt_i.ready && pnt_i.last_point |=> v1_q)
    else $error("last point did not start a result");
`endif

endmodule
